>>> rtl/jac_pkg.sv
// Types, constants and codes shared by the joystick axis conditioner.
package jac_pkg;

  localparam int unsigned CodeW   = 12;
  localparam int unsigned AxisW   = 16;
  localparam int unsigned DbW     = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned QuoW    = 15;

  localparam logic [CodeW-1:0] CodeMax      = 12'd4095;
  localparam logic [CodeW-1:0] CenterReset  = 12'd2048;
  localparam logic [DbW-1:0]   DbReset      = 15'd800;
  localparam logic [QuoW-1:0]  FullScale    = 15'd16384;
  localparam logic [13:0]      AlphaQ16     = 14'd13107;
  localparam logic [3:0]       DivLastStep  = 4'd14;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER   = 2'd0,
    CFG_DEADBAND = 2'd1,
    CFG_INV_X    = 2'd2,
    CFG_INV_Y    = 2'd3
  } cfg_idx_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FILT = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  typedef struct packed {
    logic [CodeW-1:0] x_code;
    logic [CodeW-1:0] y_code;
  } in_word_t;

  typedef struct packed {
    logic signed [AxisW-1:0] x_axis;
    logic signed [AxisW-1:0] y_axis;
  } out_word_t;

endpackage

>>> rtl/joystick_axis_conditioner.sv
// Two-axis joystick conditioner: center normalize, clamp, invert, low-pass, deadband.
//
//   channel | ports                         | word
//   --------+-------------------------------+--------------------------------
//   input   | in_valid, in_ready, in_data   | x_code, y_code (12 bit unsigned)
//   output  | out_valid, out_ready, out_data| x_axis, y_axis (16 bit signed)
//   config  | cfg_we, cfg_index, cfg_wdata  | center, deadband, invert x/y
//
// Each accepted word is processed per axis, X then Y: setup, 15 steps of the
// shared restoring divider, multiply, filter update; then one output load, at
// which the sequencer returns to idle. A new word is accepted only after the
// previous one has been loaded into the output register.
// in_ready is high only while the sequencer is idle. A finished word waits in
// the output register; a second finished word holds in the last state until
// the first is taken. Synchronous reset loads the register defaults and
// clears both filter states.
module joystick_axis_conditioner (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  jac_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output jac_pkg::out_word_t                   out_data,
  input  logic                                 cfg_we,
  input  logic [jac_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [jac_pkg::CfgW-1:0]             cfg_wdata
);

  // Configuration registers.
  logic [jac_pkg::CodeW-1:0] center_r;
  logic [jac_pkg::DbW-1:0]   deadband_r;
  logic                      inv_x_r;
  logic                      inv_y_r;

  // Sequencer and datapath registers.
  jac_pkg::state_t            state_r, state_nxt;
  jac_pkg::in_word_t          in_hold_r;
  logic                       axis_r;          // 0: X, 1: Y
  logic [12:0]                rem_r;
  logic [jac_pkg::CodeW-1:0]  div_r;
  logic [jac_pkg::QuoW-1:0]   quo_r;
  logic [3:0]                 cnt_r;
  logic                       neg_r;
  logic signed [31:0]         prod_r;
  logic signed [jac_pkg::AxisW-1:0] x_filt_r, y_filt_r;
  logic                       out_valid_r;
  jac_pkg::out_word_t         out_data_r;

  // Setup for the current axis.
  logic [jac_pkg::CodeW-1:0]  code_w;
  logic                       ge_w;
  logic [jac_pkg::CodeW-1:0]  mag_w;
  logic [jac_pkg::CodeW-1:0]  divisor_w;
  logic                       inv_w;

  // Divider step.
  logic                       take_w;
  logic [12:0]                rem_sub_w;

  // Normalized value and filter.
  logic [jac_pkg::QuoW-1:0]   q_w;
  logic signed [jac_pkg::AxisW-1:0] n_w;
  logic signed [jac_pkg::AxisW-1:0] cur_state_w;
  logic signed [16:0]         e_w;
  logic signed [31:0]         prod_nxt;
  logic signed [16:0]         step_w;
  logic signed [16:0]         s_w;
  logic signed [16:0]         db_w;
  logic signed [jac_pkg::AxisW-1:0] s_final_w;
  logic                       out_free_w;

  assign in_ready  = (state_r == jac_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free_w = !out_valid_r || out_ready;

  always_comb begin
    code_w    = axis_r ? in_hold_r.y_code : in_hold_r.x_code;
    inv_w     = axis_r ? inv_y_r : inv_x_r;
    ge_w      = (code_w >= center_r);
    mag_w     = ge_w ? (code_w - center_r) : (center_r - code_w);
    divisor_w = ge_w ? (jac_pkg::CodeMax - center_r) : center_r;
  end

  // Restoring step: compare, subtract when it fits.
  assign take_w    = (rem_r >= {1'b0, div_r});
  assign rem_sub_w = take_w ? (rem_r - {1'b0, div_r}) : rem_r;

  always_comb begin
    // A zero divisor only meets a zero offset; read it as zero.
    if (div_r == '0) begin
      q_w = '0;
    end else if (quo_r > jac_pkg::FullScale) begin
      q_w = jac_pkg::FullScale;
    end else begin
      q_w = quo_r;
    end
    n_w         = neg_r ? -$signed({1'b0, q_w}) : $signed({1'b0, q_w});
    cur_state_w = axis_r ? y_filt_r : x_filt_r;
    e_w         = 17'(n_w) - 17'(cur_state_w);
    prod_nxt    = e_w * $signed({1'b0, jac_pkg::AlphaQ16});
    // Arithmetic shift floors toward minus infinity.
    step_w      = 17'(prod_r >>> 16);
    s_w         = 17'(cur_state_w) + step_w;
    db_w        = $signed({2'b00, deadband_r});
    if ((s_w > -db_w) && (s_w < db_w)) begin
      s_final_w = '0;
    end else begin
      s_final_w = s_w[jac_pkg::AxisW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      jac_pkg::S_IDLE: if (in_valid) state_nxt = jac_pkg::S_LOAD;
      jac_pkg::S_LOAD: state_nxt = jac_pkg::S_DIV;
      jac_pkg::S_DIV:  if (cnt_r == jac_pkg::DivLastStep) state_nxt = jac_pkg::S_MUL;
      jac_pkg::S_MUL:  state_nxt = jac_pkg::S_FILT;
      jac_pkg::S_FILT: state_nxt = axis_r ? jac_pkg::S_DONE : jac_pkg::S_LOAD;
      jac_pkg::S_DONE: if (out_free_w) state_nxt = jac_pkg::S_IDLE;
      default:         state_nxt = jac_pkg::S_IDLE;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r   <= jac_pkg::CenterReset;
      deadband_r <= jac_pkg::DbReset;
      inv_x_r    <= 1'b0;
      inv_y_r    <= 1'b0;
    end else if (cfg_we) begin
      case (jac_pkg::cfg_idx_t'(cfg_index))
        jac_pkg::CFG_CENTER:   center_r   <= cfg_wdata[jac_pkg::CodeW-1:0];
        jac_pkg::CFG_DEADBAND: deadband_r <= cfg_wdata[jac_pkg::DbW-1:0];
        jac_pkg::CFG_INV_X:    inv_x_r    <= cfg_wdata[0];
        jac_pkg::CFG_INV_Y:    inv_y_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jac_pkg::S_IDLE;
      axis_r      <= 1'b0;
      cnt_r       <= '0;
      x_filt_r    <= '0;
      y_filt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Load a finished word when the output frees up; drop valid once taken.
      if ((state_r == jac_pkg::S_DONE) && out_free_w) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        jac_pkg::S_IDLE: begin
          axis_r <= 1'b0;
        end
        jac_pkg::S_LOAD: begin
          cnt_r <= '0;
        end
        jac_pkg::S_DIV: begin
          cnt_r <= cnt_r + 4'd1;
        end
        jac_pkg::S_FILT: begin
          // Store the deadband-zeroed value back as the filter state.
          if (axis_r) y_filt_r <= s_final_w;
          else        x_filt_r <= s_final_w;
          axis_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (state_r)
      jac_pkg::S_IDLE: begin
        if (in_valid) in_hold_r <= in_data;
      end
      jac_pkg::S_LOAD: begin
        rem_r <= {1'b0, mag_w};
        div_r <= divisor_w;
        quo_r <= '0;
        neg_r <= (!ge_w) ^ inv_w;
      end
      jac_pkg::S_DIV: begin
        // Shift in one quotient bit; advance the partial remainder.
        quo_r <= {quo_r[jac_pkg::QuoW-2:0], take_w};
        rem_r <= {rem_sub_w[11:0], 1'b0};
      end
      jac_pkg::S_MUL: begin
        prod_r <= prod_nxt;
      end
      jac_pkg::S_DONE: begin
        if (out_free_w) begin
          out_data_r.x_axis <= x_filt_r;
          out_data_r.y_axis <= y_filt_r;
        end
      end
      default: ;
    endcase
  end

endmodule
